### sv/pbts_pkg.sv
// package for the priority bitmap task scheduler
// holds command codes, domain status codes, shared types and defaults
package pbts_pkg;

  localparam int unsigned NumLevelsDefault  = 32;
  localparam int unsigned NumDomainsDefault = 16;
  localparam int unsigned KindW             = 4;
  localparam int unsigned DomW              = 4;
  localparam int unsigned PrioW             = 5;
  localparam int unsigned QueueDepth        = 2;

  typedef enum logic [3:0] {
    CmdStart  = 4'd0,
    CmdAdd    = 4'd1,
    CmdDelete = 4'd2,
    CmdSleep  = 4'd3,
    CmdWake   = 4'd4,
    CmdKill   = 4'd5,
    CmdStop   = 4'd6,
    CmdYield  = 4'd7,
    CmdRun    = 4'd8,
    CmdPick   = 4'd9,
    CmdPut    = 4'd10,
    CmdTick   = 4'd11
  } cmd_e;

  typedef enum logic [2:0] {
    StReady = 3'd0,
    StRun   = 3'd1,
    StSleep = 3'd2,
    StDead  = 3'd3,
    StStop  = 3'd4
  } dom_status_e;

  // request handed from the front to the back
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DomW-1:0]  domain_id;
    logic [PrioW-1:0] priority_req;
    logic             dom_ok;
  } cmd_req_t;

  // result of one request
  typedef struct packed {
    logic            status;
    logic [DomW-1:0] selected_domain;
    logic            resched_request;
  } cmd_rsp_t;

  typedef enum logic [3:0] {
    ExIdle,
    ExUnlinkRd,
    ExUnlinkWr,
    ExAppendRd,
    ExAppendWr,
    ExPickScan,
    ExPickRd,
    ExFinish
  } exec_state_e;

endpackage

### sv/pbts_front.sv
// front end: accepts commands, checks the domain range, fills a short queue
// depends on pbts_pkg
module pbts_front #(
  parameter int unsigned NumDomains = pbts_pkg::NumDomainsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [3:0]           kind_i,
  input  logic [3:0]           domain_id_i,
  input  logic [4:0]           priority_req_i,
  output logic                 req_valid_o,
  input  logic                 req_take_i,
  output pbts_pkg::cmd_req_t   req_o
);

  localparam int unsigned Depth = pbts_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  pbts_pkg::cmd_req_t    mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]         cnt_q, cnt_d;
  pbts_pkg::cmd_req_t    new_req;
  logic                  do_push, do_pop;

  // classify the incoming request
  always_comb begin
    new_req.kind         = kind_i;
    new_req.domain_id    = domain_id_i;
    new_req.priority_req = priority_req_i;
    new_req.dom_ok       = ({28'd0, domain_id_i} < 32'(NumDomains));
  end

  assign full        = (cnt_q == (PtrW+1)'(Depth));
  assign do_push     = push && !full;
  assign req_valid_o = (cnt_q != '0);
  assign do_pop      = req_valid_o && req_take_i;
  assign req_o       = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_req;
    end
  end

endmodule

### sv/pbts_back.sv
// back end: carries out one scheduler request over several cycles
// depends on pbts_pkg; holds the level queues and per-domain state
module pbts_back #(
  parameter int unsigned NumLevels  = pbts_pkg::NumLevelsDefault,
  parameter int unsigned NumDomains = pbts_pkg::NumDomainsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rr_mode_i,
  input  logic                 req_valid_i,
  output logic                 req_take_o,
  input  pbts_pkg::cmd_req_t   req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_full_i,
  output pbts_pkg::cmd_rsp_t   rsp_o
);

  localparam int unsigned LvlW = $clog2(NumLevels);
  localparam int unsigned DomW = $clog2(NumDomains);

  typedef logic [LvlW-1:0] lvl_t;
  typedef logic [DomW-1:0] dom_t;

  // level queues and domain tables
  logic [NumLevels-1:0]  map_q;
  dom_t                  head_q [NumLevels];
  dom_t                  tail_q [NumLevels];
  dom_t                  next_q [NumDomains];
  dom_t                  prev_q [NumDomains];
  lvl_t                  level_q [NumDomains];
  pbts_pkg::dom_status_e status_q [NumDomains];
  logic [NumDomains-1:0] queued_q;
  logic [7:0]            left_q [NumDomains];
  logic [31:0]           used_q [NumDomains];
  dom_t                  run_q;

  pbts_pkg::exec_state_e state_q, state_d;
  pbts_pkg::cmd_req_t    cmd_q;
  dom_t                  dom_q;
  lvl_t                  lvl_q;
  logic                  append_q;
  logic                  st_q, rs_q;
  lvl_t                  scan_lvl;
  logic                  scan_hit;
  // values read for the unlink and append steps
  dom_t                  rd_head_q, rd_tail_q, rd_next_q, rd_prev_q;
  logic                  rd_nonempty_q;

  logic [3:0]            kind;
  dom_t                  req_dom;
  logic                  dec_st, dec_rs, dec_append;
  dom_t                  dec_dom;
  logic                  unlink_need;

  assign kind    = req_i.kind;
  assign req_dom = req_i.domain_id[DomW-1:0];

  // saturated level of the request being carried out
  function automatic lvl_t req_lvl_q();
    return ({27'd0, cmd_q.priority_req} >= 32'(NumLevels)) ?
           lvl_t'(NumLevels - 1) : cmd_q.priority_req[LvlW-1:0];
  endfunction

  // find lowest non-empty level
  always_comb begin
    scan_lvl = '0;
    scan_hit = 1'b0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (map_q[i]) begin
        scan_lvl = lvl_t'(i);
        scan_hit = 1'b1;
      end
    end
  end

  // decode request into status, reschedule and append work
  always_comb begin
    dec_st     = 1'b0;
    dec_rs     = 1'b0;
    dec_append = 1'b0;
    dec_dom    = req_dom;
    case (kind)
      pbts_pkg::CmdStart: begin
        if (req_i.dom_ok) begin
          if (status_q[req_dom] != pbts_pkg::StReady) dec_st = 1'b1;
          else dec_append = 1'b1;
        end
      end
      pbts_pkg::CmdAdd, pbts_pkg::CmdWake: begin
        dec_append = req_i.dom_ok;
      end
      pbts_pkg::CmdDelete, pbts_pkg::CmdSleep,
      pbts_pkg::CmdKill, pbts_pkg::CmdStop: begin
        dec_rs = req_i.dom_ok && (kind != pbts_pkg::CmdDelete);
      end
      pbts_pkg::CmdYield: begin
        dec_dom    = run_q;
        dec_append = 1'b1;
        dec_rs     = 1'b1;
      end
      pbts_pkg::CmdPut: begin
        dec_append = req_i.dom_ok && rr_mode_i && req_dom != '0 &&
                     left_q[req_dom] == 8'd0;
      end
      pbts_pkg::CmdTick: begin
        dec_rs = rr_mode_i && run_q != '0 && left_q[run_q] <= 8'd1;
      end
      default: ;
    endcase
  end

  // only appending requests and valid-domain delete, sleep, kill and stop need unlinking
  assign unlink_need = append_q || (cmd_q.dom_ok &&
                       (cmd_q.kind == pbts_pkg::CmdDelete || cmd_q.kind == pbts_pkg::CmdSleep ||
                        cmd_q.kind == pbts_pkg::CmdKill || cmd_q.kind == pbts_pkg::CmdStop));

  assign req_take_o  = (state_q == pbts_pkg::ExIdle) && req_valid_i;
  assign rsp_valid_o = (state_q == pbts_pkg::ExFinish);
  assign rsp_o.status          = st_q;
  assign rsp_o.selected_domain = 4'(run_q);
  assign rsp_o.resched_request = rs_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pbts_pkg::ExIdle: begin
        if (req_valid_i) begin
          state_d = (kind == pbts_pkg::CmdPick) ? pbts_pkg::ExPickScan : pbts_pkg::ExUnlinkRd;
        end
      end
      pbts_pkg::ExUnlinkRd: begin
        state_d = unlink_need ? pbts_pkg::ExUnlinkWr : pbts_pkg::ExFinish;
      end
      pbts_pkg::ExUnlinkWr: begin
        state_d = append_q ? pbts_pkg::ExAppendRd : pbts_pkg::ExFinish;
      end
      pbts_pkg::ExAppendRd: state_d = pbts_pkg::ExAppendWr;
      pbts_pkg::ExAppendWr: state_d = pbts_pkg::ExFinish;
      pbts_pkg::ExPickScan: state_d = pbts_pkg::ExPickRd;
      pbts_pkg::ExPickRd:   state_d = pbts_pkg::ExFinish;
      pbts_pkg::ExFinish: begin
        if (!rsp_full_i) state_d = pbts_pkg::ExIdle;
      end
      default: state_d = pbts_pkg::ExIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pbts_pkg::ExIdle;
      map_q    <= '0;
      queued_q <= '0;
      run_q    <= '0;
      append_q <= 1'b0;
      st_q     <= 1'b0;
      rs_q     <= 1'b0;
      for (int i = 0; i < NumDomains; i++) begin
        level_q[i]  <= '0;
        status_q[i] <= pbts_pkg::StReady;
        left_q[i]   <= '0;
        used_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        pbts_pkg::ExIdle: begin
          if (req_valid_i) begin
            cmd_q    <= req_i;
            st_q     <= dec_st;
            rs_q     <= dec_rs;
            append_q <= dec_append;
            dom_q    <= dec_dom;
            // per-domain table updates of the request
            case (kind)
              pbts_pkg::CmdStart: begin
                if (dec_append) left_q[req_dom] <= 8'd1;
              end
              pbts_pkg::CmdDelete, pbts_pkg::CmdSleep,
              pbts_pkg::CmdKill, pbts_pkg::CmdStop: begin
                if (req_i.dom_ok) begin
                  status_q[req_dom] <= (kind == pbts_pkg::CmdSleep) ? pbts_pkg::StSleep :
                                       (kind == pbts_pkg::CmdStop) ? pbts_pkg::StStop :
                                       pbts_pkg::StDead;
                end
              end
              pbts_pkg::CmdRun: begin
                if (req_i.dom_ok) status_q[req_dom] <= pbts_pkg::StRun;
              end
              pbts_pkg::CmdPut: begin
                if (dec_append) left_q[req_dom] <= 8'd1;
              end
              pbts_pkg::CmdTick: begin
                if (!rr_mode_i) begin
                  used_q[run_q] <= used_q[run_q] + 32'd1;
                end else if (run_q != '0) begin
                  used_q[run_q] <= used_q[run_q] + 32'd1;
                  if (left_q[run_q] > 8'd1) begin
                    left_q[run_q] <= left_q[run_q] - 8'd1;
                  end else begin
                    left_q[run_q] <= 8'd0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        pbts_pkg::ExUnlinkRd: begin
          lvl_q         <= level_q[dom_q];
          rd_head_q     <= head_q[level_q[dom_q]];
          rd_tail_q     <= tail_q[level_q[dom_q]];
          rd_next_q     <= next_q[dom_q];
          rd_prev_q     <= prev_q[dom_q];
        end
        pbts_pkg::ExUnlinkWr: begin
          if (queued_q[dom_q]) begin
            if (rd_head_q == dom_q && rd_tail_q == dom_q) map_q[lvl_q] <= 1'b0;
            else if (rd_head_q == dom_q) head_q[lvl_q] <= rd_next_q;
            else if (rd_tail_q == dom_q) tail_q[lvl_q] <= rd_prev_q;
            else begin
              next_q[rd_prev_q] <= rd_next_q;
              prev_q[rd_next_q] <= rd_prev_q;
            end
            queued_q[dom_q] <= 1'b0;
          end
          // start and add record the new level
          if (cmd_q.kind == pbts_pkg::CmdStart || cmd_q.kind == pbts_pkg::CmdAdd) begin
            level_q[dom_q] <= req_lvl_q();
          end
        end
        pbts_pkg::ExAppendRd: begin
          lvl_q         <= level_q[dom_q];
          rd_tail_q     <= tail_q[level_q[dom_q]];
          rd_nonempty_q <= map_q[level_q[dom_q]];
        end
        pbts_pkg::ExAppendWr: begin
          if (rd_nonempty_q) begin
            next_q[rd_tail_q] <= dom_q;
            prev_q[dom_q]     <= rd_tail_q;
            tail_q[lvl_q]     <= dom_q;
          end else begin
            head_q[lvl_q] <= dom_q;
            tail_q[lvl_q] <= dom_q;
            map_q[lvl_q]  <= 1'b1;
          end
          queued_q[dom_q] <= 1'b1;
          status_q[dom_q] <= pbts_pkg::StReady;
        end
        pbts_pkg::ExPickScan: begin
          lvl_q         <= scan_lvl;
          rd_nonempty_q <= scan_hit;
        end
        pbts_pkg::ExPickRd: begin
          run_q <= rd_nonempty_q ? head_q[lvl_q] : '0;
        end
        pbts_pkg::ExFinish: ;
        default: ;
      endcase
    end
  end

endmodule

### sv/pbts_out.sv
// result queue between the back end and the result ports
// depends on pbts_pkg
module pbts_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rsp_valid_i,
  output logic               rsp_full_o,
  input  pbts_pkg::cmd_rsp_t rsp_i,
  output logic               empty,
  input  logic               pop,
  output pbts_pkg::cmd_rsp_t rsp_o
);

  logic               valid_q, valid_d;
  pbts_pkg::cmd_rsp_t data_q;

  assign empty      = !valid_q;
  assign rsp_full_o = valid_q && !pop;
  assign rsp_o      = data_q;

  // hold one result until popped
  always_comb begin
    valid_d = valid_q;
    if (pop && valid_q) valid_d = 1'b0;
    if (rsp_valid_i && !rsp_full_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid_i && !rsp_full_o) data_q <= rsp_i;
  end

endmodule

### sv/priority_bitmap_task_scheduler_core.sv
// Scheduler with priority levels, each a linked FIFO of domains, and a bitmap
// of non-empty levels. Back end states: a command that touches no list goes idle,
// unlink read, finish; pick goes idle, scan, read, finish; removals go idle, unlink
// read, unlink write, finish; appends add append read and write before finish.
// One command at a time; requests pass a registered queue, results a register.
// depends on pbts_pkg, pbts_front, pbts_back, pbts_out
module priority_bitmap_task_scheduler_core #(
  parameter int unsigned NumLevels  = pbts_pkg::NumLevelsDefault,
  parameter int unsigned NumDomains = pbts_pkg::NumDomainsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [3:0] kind_i,
  input  logic [3:0] domain_id_i,
  input  logic [4:0] priority_req_i,
  output logic       empty,
  input  logic       pop,
  output logic       status_o,
  output logic [3:0] selected_domain_o,
  output logic       resched_request_o
);

  logic               rr_mode_q;
  logic               req_valid, req_take, rsp_valid, rsp_full;
  pbts_pkg::cmd_req_t req;
  pbts_pkg::cmd_rsp_t rsp, out_rsp;

  // round-robin mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      rr_mode_q <= cfg_wdata_i;
    end
  end

  pbts_front #(.NumDomains(NumDomains)) u_front (
    .clk_i, .rst_ni, .push, .full, .kind_i, .domain_id_i, .priority_req_i,
    .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req)
  );

  pbts_back #(.NumLevels(NumLevels), .NumDomains(NumDomains)) u_back (
    .clk_i, .rst_ni, .rr_mode_i(rr_mode_q), .req_valid_i(req_valid),
    .req_take_o(req_take), .req_i(req), .rsp_valid_o(rsp_valid),
    .rsp_full_i(rsp_full), .rsp_o(rsp)
  );

  pbts_out u_out (
    .clk_i, .rst_ni, .rsp_valid_i(rsp_valid), .rsp_full_o(rsp_full), .rsp_i(rsp),
    .empty, .pop, .rsp_o(out_rsp)
  );

  assign status_o          = out_rsp.status;
  assign selected_domain_o = out_rsp.selected_domain;
  assign resched_request_o = out_rsp.resched_request;

endmodule

### sv/pbts_checker.sv
// port-level checks for the scheduler core
// depends on priority_bitmap_task_scheduler_core ports
module pbts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       status_o,
  input logic [3:0] kind_i,
  input logic [3:0] selected_domain_o
);

  logic [2:0] inflight_q, inflight_d;

  // requests accepted and not yet popped
  assign inflight_d = inflight_q + 3'(push && !full) - 3'(pop && !empty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable({status_o, selected_domain_o}) && !empty))
    else $error("result changed while waiting");

  // nothing is shown right out of reset
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result after reset");

  // a result cannot appear without an earlier request
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (inflight_q != 3'd0))
    else $error("unexpected result");

  // an accepted request carries a known command
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> !$isunknown(kind_i))
    else $error("unknown command accepted");

endmodule

bind priority_bitmap_task_scheduler_core pbts_checker u_pbts_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .status_o, .kind_i,
  .selected_domain_o
);
